### src/sfts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted fixup table search: shared definitions
// Widths of the item fields, request codes and the default table depth.
// ----------------------------------------------------------------------------
package sfts_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int WORD_W          = 32;
    localparam int INDEX_W         = 8;
    localparam int COUNT_W         = 9;

    typedef enum logic
    {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } req_t;

endpackage

### src/sorted_fixup_table_search_top.sv
// ----------------------------------------------------------------------------
// Sorted fixup table search: top level
// A table of (faulting address, fixup address) pairs searched by a lower-bound
// binary search, one table probe per clock cycle.
// ----------------------------------------------------------------------------
// A write item (req_type = 0) stores one entry in the cycle it is accepted and
// gives no result; busy stays low, so the next item may follow at once. A
// search item (req_type = 1) holds busy high while it searches the first n
// entries, where n is the entry count limited to the table depth, and its
// result is shown on found and fixup_addr with done high for exactly one
// cycle right after busy falls. An empty table gives its result in the cycle
// after acceptance with busy staying low.
// The search length is set by the single-port table memory: every halving of
// the search interval needs one registered read, and a last read checks the
// final slot.
// The receiver cannot stall; a result that is not taken in its cycle is lost.
// The entry count is written through the configuration channel, which is
// always ready and should only be used while no search is in progress.
// ----------------------------------------------------------------------------
module sorted_fixup_table_search_top
    import sfts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [WORD_W-1:0]  entry_key,
    input  logic [WORD_W-1:0]  entry_fixup,
    input  logic [WORD_W-1:0]  search_key,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    output logic               done,
    output logic               found,
    output logic [WORD_W-1:0]  fixup_addr
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0]
    {
        S_IDLE   = 3'b001,
        S_ISSUE  = 3'b010,
        S_SEARCH = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     lo_reg, lo_next;
    logic [ADDR_W-1:0]     hi_reg, hi_next;
    logic [ADDR_W-1:0]     mid_reg;
    logic                  final_reg;
    logic [WORD_W-1:0]     target_reg;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [WORD_W-1:0]     fixup_reg, fixup_next;

    logic                  accept;
    logic                  cfg_write;
    logic [WORD_W-1:0]     index_wide;
    logic                  index_in_range;
    logic [CNT_W-1:0]      count_sat;
    logic [CNT_W-1:0]      count_minus_one;
    logic                  probe_final;
    logic [ADDR_W-1:0]     probe_mid;
    logic [ADDR_W-1:0]     probe_addr;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [2*WORD_W-1:0]   ram_wdata;
    logic [2*WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]     rd_key;
    logic [WORD_W-1:0]     rd_fixup;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // An entry count beyond the table depth is clipped when it is written.
    assign count_sat = ({{(WORD_W-COUNT_W){1'b0}}, cfg_data} > WORD_W'(TABLE_DEPTH))
                       ? CNT_W'(TABLE_DEPTH)
                       : CNT_W'(cfg_data);
    assign count_minus_one = count_reg - CNT_W'(1);

    // Writes to a slot that lies beyond the table depth are dropped.
    assign index_wide     = WORD_W'(entry_index);
    assign index_in_range = index_wide < WORD_W'(TABLE_DEPTH);

    assign rd_key   = ram_rdata[WORD_W-1:0];
    assign rd_fixup = ram_rdata[2*WORD_W-1:WORD_W];

    // Interval update for the probe just returned, then the next probe
    // address. Once the interval has shrunk to one slot, that slot is read
    // for the final comparison.
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        fixup_next = fixup_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_SEARCH))
                begin
                    if (count_reg == '0)
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        fixup_next = '0;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = count_minus_one[ADDR_W-1:0];
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (final_reg)
                begin
                    done_next  = 1'b1;
                    found_next = (rd_key == target_reg);
                    fixup_next = (rd_key == target_reg) ? rd_fixup : '0;
                    state_next = S_IDLE;
                end
                else if (rd_key < target_reg)
                begin
                    lo_next = mid_reg + ADDR_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign probe_final = !(lo_next < hi_next);
    assign probe_mid   = lo_next + ((hi_next - lo_next) >> 1);
    assign probe_addr  = probe_final ? lo_next : probe_mid;

    // The memory port serves the entry write in the idle state and the
    // search probes otherwise.
    assign ram_we    = accept && (req_type == REQ_WRITE) && index_in_range;
    assign ram_addr  = (state_reg == S_IDLE) ? index_wide[ADDR_W-1:0] : probe_addr;
    assign ram_wdata = {entry_fixup, entry_key};

    sfts_ram #(
        .WIDTH (2 * WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                count_reg <= count_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        found_reg <= found_next;
        fixup_reg <= fixup_next;
        if (state_reg != S_IDLE)
        begin
            mid_reg   <= probe_addr;
            final_reg <= probe_final;
        end
        if (accept)
        begin
            target_reg <= search_key;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign fixup_addr = fixup_reg;

    // A result only follows the final probe or a search of an empty table.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_SEARCH) || ($past(accept) && !$past(busy)))
        else $error("result strobe without a finished search");

    // The probe issue cycle is always followed by the probing loop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |=> (state_reg == S_SEARCH))
        else $error("search did not enter the probing loop");

    // The search interval never inverts while probing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg))
        else $error("search interval inverted");

    // A miss always reports a zero fixup address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |-> (fixup_reg == '0))
        else $error("non-zero fixup address on a miss");

    // The table is never written in the middle of a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("table write during a search");

endmodule

### src/sfts_ram.sv
// ----------------------------------------------------------------------------
// Sorted fixup table search: generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module sfts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
